// File: rtl/olte_pkg.sv
// Shared constants, codes and types for the ordered list table engine.
// No dependencies; every other file refers to it by scoped names.
package olte_pkg;

  // Store geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Payload widths
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND  = 3'd0,
    FN_LIST    = 3'd1,
    FN_SEARCH  = 3'd2,
    FN_DEL_VAL = 3'd3,
    FN_DEL_POS = 3'd4
  } func_e;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Store access: one write port, one read port
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    idx_t  raddr;
  } mem_req_t;

  // Shared walk unit results
  typedef struct packed {
    cnt_t nxt;     // index plus one
    logic at_end;  // index is the tail entry
    logic eq;      // stored entry equals the key
  } alu_res_t;

endpackage

// File: rtl/olte_if.sv
// Handshake interfaces for the input and result channels.
// Depends on olte_pkg for payload types.
interface olte_in_if;
  logic                          valid;
  logic                          ready;
  logic [olte_pkg::FUNC_W-1:0]   func;
  logic signed [olte_pkg::DATA_W-1:0] value;
  logic [olte_pkg::POS_W-1:0]    position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface olte_out_if;
  logic                          valid;
  logic                          ready;
  logic [olte_pkg::STAT_W-1:0]   status;
  logic signed [olte_pkg::DATA_W-1:0] item;
  logic                          last;

  modport source (output valid, status, item, last, input ready);
  modport sink   (input valid, status, item, last, output ready);
endinterface

// File: rtl/olte_store.sv
// Entry store: one write port, one read port with registered read data.
// Depends on olte_pkg.
module olte_store (
  input  logic               clk_i,
  input  olte_pkg::mem_req_t req_i,
  output olte_pkg::data_t    rdata_o
);

  olte_pkg::data_t mem [olte_pkg::CAPACITY];
  olte_pkg::data_t rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/olte_alu.sv
// Shared walk unit: index increment, tail compare and key compare.
// Depends on olte_pkg.
module olte_alu (
  input  olte_pkg::idx_t     idx_i,
  input  olte_pkg::cnt_t     count_i,
  input  olte_pkg::data_t    a_i,
  input  olte_pkg::data_t    b_i,
  output olte_pkg::alu_res_t res_o
);

  olte_pkg::cnt_t nxt;

  assign nxt          = olte_pkg::CNT_W'(idx_i) + olte_pkg::CNT_W'(1);
  assign res_o.nxt    = nxt;
  assign res_o.at_end = (nxt == count_i);
  assign res_o.eq     = (a_i == b_i);

endmodule

// File: rtl/ordered_list_table_engine.sv
// Ordered list table engine top: sequencer, output register, walk unit and store.
// Depends on olte_pkg, olte_if, olte_alu and olte_store.
//
//  port   dir  kind         payload
//  in_i   in   valid/ready  func, value, position
//  out_o  out  valid/ready  status, item, last
//
// Append writes the store and registers its result; search and delete by
// value walk each entry through a read state and a check state, since each
// store read has registered read data. Deletes then move each entry toward
// the head through a read state and a write state (read, write). List all
// steps each entry through read, compare and result, and waits while a result is held.
// in_i.ready is low from an accepted transfer until its last result is taken.
// Reset empties the list at once; no clearing pass is needed.
module ordered_list_table_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  olte_in_if.sink    in_i,
  olte_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_SHRD,
    S_SHWR,
    S_OUT
  } state_e;

  typedef struct packed {
    olte_pkg::status_e status;
    olte_pkg::data_t   item;
    logic              last;
  } out_t;

  state_e             state_q;
  olte_pkg::cnt_t     count_q;
  olte_pkg::idx_t     idx_q;
  olte_pkg::func_e    func_q;
  olte_pkg::data_t    value_q;
  logic               cont_q;
  logic               out_valid_q;
  out_t               out_q;
  olte_pkg::data_t    rdata;
  olte_pkg::alu_res_t alu;
  olte_pkg::mem_req_t mem_req;
  logic               full;
  logic               empty;

  assign full  = (count_q == olte_pkg::CNT_W'(olte_pkg::CAPACITY));
  assign empty = (count_q == '0);

  // Shared walk unit
  olte_alu u_alu (
    .idx_i   (idx_q),
    .count_i (count_q),
    .a_i     (rdata),
    .b_i     (value_q),
    .res_o   (alu)
  );

  // Store port control
  always_comb begin
    mem_req.we    = (state_q == S_SHWR) ||
                    ((state_q == S_IDLE) && in_i.valid &&
                     (olte_pkg::func_e'(in_i.func) == olte_pkg::FN_APPEND) && !full);
    mem_req.waddr = (state_q == S_SHWR) ? idx_q : count_q[olte_pkg::IDX_W-1:0];
    mem_req.wdata = (state_q == S_SHWR) ? rdata : in_i.value;
    mem_req.raddr = (state_q == S_SHRD) ? alu.nxt[olte_pkg::IDX_W-1:0] : idx_q;
  end

  olte_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      func_q      <= olte_pkg::FN_APPEND;
      value_q     <= '0;
      cont_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '{status: olte_pkg::ST_OK, item: '0, last: 1'b0};
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            func_q  <= olte_pkg::func_e'(in_i.func);
            value_q <= in_i.value;
            idx_q   <= '0;
            cont_q  <= 1'b0;
            unique case (olte_pkg::func_e'(in_i.func))
              olte_pkg::FN_APPEND: begin
                if (full) begin
                  out_q <= '{status: olte_pkg::ST_FULL, item: '0, last: 1'b1};
                end else begin
                  count_q <= count_q + olte_pkg::CNT_W'(1);
                  out_q   <= '{status: olte_pkg::ST_OK, item: '0, last: 1'b1};
                end
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
              olte_pkg::FN_LIST: begin
                if (empty) begin
                  out_q       <= '{status: olte_pkg::ST_EMPTY, item: '0, last: 1'b1};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_RD;
                end
              end
              olte_pkg::FN_SEARCH, olte_pkg::FN_DEL_VAL: begin
                if (empty) begin
                  out_q       <= '{status: olte_pkg::ST_MISS, item: '0, last: 1'b1};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end else begin
                  state_q <= S_RD;
                end
              end
              olte_pkg::FN_DEL_POS: begin
                if (olte_pkg::POS_W'(count_q) > in_i.position) begin
                  idx_q   <= in_i.position[olte_pkg::IDX_W-1:0];
                  state_q <= S_SHRD;
                end else begin
                  out_q       <= '{status: olte_pkg::ST_MISS, item: '0, last: 1'b1};
                  out_valid_q <= 1'b1;
                  state_q     <= S_OUT;
                end
              end
              default: begin
                out_q       <= '{status: olte_pkg::ST_MISS, item: '0, last: 1'b1};
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end
            endcase
          end
        end

        // Read data is registered; it arrives in the cycle after the address
        S_RD: begin
          state_q <= S_CHK;
        end

        S_CHK: begin
          unique case (func_q)
            olte_pkg::FN_LIST: begin
              out_q       <= '{status: olte_pkg::ST_OK, item: rdata, last: alu.at_end};
              cont_q      <= !alu.at_end;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end
            olte_pkg::FN_SEARCH: begin
              if (alu.eq) begin
                out_q       <= '{status: olte_pkg::ST_OK, item: rdata, last: 1'b1};
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end else if (alu.at_end) begin
                out_q       <= '{status: olte_pkg::ST_MISS, item: '0, last: 1'b1};
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end else begin
                idx_q   <= alu.nxt[olte_pkg::IDX_W-1:0];
                state_q <= S_RD;
              end
            end
            olte_pkg::FN_DEL_VAL: begin
              if (alu.eq) begin
                state_q <= S_SHRD;
              end else if (alu.at_end) begin
                out_q       <= '{status: olte_pkg::ST_MISS, item: '0, last: 1'b1};
                out_valid_q <= 1'b1;
                state_q     <= S_OUT;
              end else begin
                idx_q   <= alu.nxt[olte_pkg::IDX_W-1:0];
                state_q <= S_RD;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end

        // Close the gap: read the following entry, or finish at the tail
        S_SHRD: begin
          if (alu.at_end) begin
            count_q     <= count_q - olte_pkg::CNT_W'(1);
            out_q       <= '{status: olte_pkg::ST_OK, item: '0, last: 1'b1};
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_SHWR;
          end
        end

        // Entry moved down one slot this cycle
        S_SHWR: begin
          idx_q   <= alu.nxt[olte_pkg::IDX_W-1:0];
          state_q <= S_SHRD;
        end

        // Hold the result until the transfer
        S_OUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (cont_q) begin
              idx_q   <= alu.nxt[olte_pkg::IDX_W-1:0];
              state_q <= S_RD;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_q.status;
  assign out_o.item   = out_q.item;
  assign out_o.last   = out_q.last;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= olte_pkg::CNT_W'(olte_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_valid_q)
    else $error("input ready while a result is pending");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we |-> (olte_pkg::CNT_W'(mem_req.waddr) <= count_q))
    else $error("store write beyond the tail");

  a_count_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_SHRD))
    else $error("entry count changed mid walk");

  a_partial_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (out_q.status == olte_pkg::ST_OK && cont_q))
    else $error("non-final result outside list walk");

endmodule
